### sv/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
`default_nettype none
package sfr_pkg;
   localparam int MAX_PATTERN = 16;
   // longest pattern the block handles; also the depth of the held byte line
   localparam int PAT_CAP     = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
   localparam int CNT_W       = $clog2(PAT_CAP + 1);
   localparam int IDX_W       = $clog2(PAT_CAP);
   localparam int REPL_MAX    = 16;
   localparam int REP_IDX_W   = $clog2(REPL_MAX);
   localparam int LEN_W       = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   typedef logic [7:0] byte_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LEN  = 3'd0,
      CSR_PATTERN_LOW  = 3'd1,
      CSR_PATTERN_HIGH = 3'd2,
      CSR_REPLACE_LEN  = 3'd3,
      CSR_REPLACE_LOW  = 3'd4,
      CSR_REPLACE_HIGH = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REPL,
      ST_DRAIN,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } held_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             prefix_ok;
      byte_type         head;
   } held_stat_type;

   typedef struct packed {
      logic     valid;
      byte_type char_out;
      logic     has_char;
      logic     last_out;
   } emit_type;
endpackage
`default_nettype wire

### sv/stream_find_replace_unit.sv
// An accepted beat goes through a check state, then the result beats, one per cycle
// while the output is not stalled, then a closing state; up to 16 result beats per
// accept, plus an empty end-marker state when needed. The next beat is taken only
// once the block is back in idle, so it works on one beat at a time. Results pass
// through one output register.
// Reset is synchronous, active high: held count zero, pattern_len 1, other CSRs zero.
`default_nettype none
module stream_find_replace_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_char_in,
   input  wire logic                              req_end_of_text,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_char_out,
   output logic                                   rsp_has_char,
   output logic                                   rsp_last_out
);
   import sfr_pkg::*;

   logic [LEN_W-1:0]      pattern_len_ff;
   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [LEN_W-1:0]      replace_len_ff;
   logic [CSR_DATA_W-1:0] replace_low_ff;
   logic [CSR_DATA_W-1:0] replace_high_ff;

   logic [CNT_W-1:0]         plen;
   logic [LEN_W-1:0]         rlen;
   logic [2*CSR_DATA_W-1:0]  pattern_all;
   logic [2*CSR_DATA_W-1:0]  replace_all;
   logic                     ready;
   logic                     req_fire;
   logic                     slot_free;
   held_ctrl_type            ctrl;
   held_stat_type            stat;
   emit_type                 emit;

   logic     rsp_valid_ff;
   byte_type rsp_char_ff;
   logic     rsp_has_ff;
   logic     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff  <= LEN_W'(1);
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         replace_len_ff  <= '0;
         replace_low_ff  <= '0;
         replace_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_data[LEN_W-1:0];
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_data;
            CSR_REPLACE_LEN:  replace_len_ff  <= csr_data[LEN_W-1:0];
            CSR_REPLACE_LOW:  replace_low_ff  <= csr_data;
            CSR_REPLACE_HIGH: replace_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // zero pattern length acts as one; oversize lengths saturate
   always_comb begin
      if (pattern_len_ff == '0) begin
         plen = CNT_W'(1);
      end else if (pattern_len_ff > LEN_W'(PAT_CAP)) begin
         plen = CNT_W'(PAT_CAP);
      end else begin
         plen = CNT_W'(pattern_len_ff);
      end
      if (replace_len_ff > LEN_W'(REPL_MAX)) begin
         rlen = LEN_W'(REPL_MAX);
      end else begin
         rlen = replace_len_ff;
      end
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};
   assign replace_all = {replace_high_ff, replace_low_ff};

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ready;
   assign req_fire  = req_valid && ready;

   sfr_held u_held (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .char_in       (req_char_in),
      .pattern_bytes (pattern_all[PAT_CAP*8-1:0]),
      .stat          (stat)
   );

   sfr_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_eot       (req_end_of_text),
      .slot_free     (slot_free),
      .stat          (stat),
      .plen          (plen),
      .rlen          (rlen),
      .replace_bytes (replace_all[REPL_MAX*8-1:0]),
      .ready         (ready),
      .ctrl          (ctrl),
      .emit          (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.valid) begin
         rsp_char_ff <= emit.char_out;
         rsp_has_ff  <= emit.has_char;
         rsp_last_ff <= emit.last_out;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_has_char = rsp_has_ff;
   assign rsp_last_out = rsp_last_ff;
endmodule
`default_nettype wire

### sv/sfr_held.sv
// Held byte shift line with the parallel prefix compare against the pattern.
`default_nettype none
module sfr_held (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sfr_pkg::held_ctrl_type            ctrl,
   input  wire sfr_pkg::byte_type                 char_in,
   input  wire logic [sfr_pkg::PAT_CAP*8-1:0]     pattern_bytes,
   output sfr_pkg::held_stat_type                 stat
);
   import sfr_pkg::*;

   byte_type         held_ff [PAT_CAP];
   byte_type         held_in [PAT_CAP];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [PAT_CAP-1:0] mismatch;
   logic [PAT_CAP-1:0] in_range;

   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.load) begin
         held_in[count_ff[IDX_W-1:0]] = char_in;
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.shift) begin
         for (int i = 0; i < PAT_CAP - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
         count_in = count_ff - CNT_W'(1);
      end
   end

   // prefix test over the first count entries, all bytes compared at once
   always_comb begin
      for (int i = 0; i < PAT_CAP; i++) begin
         mismatch[i] = (held_ff[i] != pattern_bytes[8*i +: 8]);
         in_range[i] = (CNT_W'(i) < count_ff);
      end
   end

   assign stat.count     = count_ff;
   assign stat.prefix_ok = ~|(mismatch & in_range);
   assign stat.head      = held_ff[0];

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

### sv/sfr_seq.sv
// Sequencer: match decision, replacement emission, drain and end-of-text flush.
`default_nettype none
module sfr_seq (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_fire,
   input  wire logic                                req_eot,
   input  wire logic                                slot_free,
   input  wire sfr_pkg::held_stat_type              stat,
   input  wire logic [sfr_pkg::CNT_W-1:0]           plen,
   input  wire logic [sfr_pkg::LEN_W-1:0]           rlen,
   input  wire logic [sfr_pkg::REPL_MAX*8-1:0]      replace_bytes,
   output logic                                     ready,
   output sfr_pkg::held_ctrl_type                   ctrl,
   output sfr_pkg::emit_type                        emit
);
   import sfr_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic             eot_ff;
   logic             eot_in;
   logic             emitted_ff;
   logic             emitted_in;
   logic [LEN_W-1:0] ri_ff;
   logic [LEN_W-1:0] ri_in;
   logic             match;
   logic             drain_go;
   logic             repl_go;

   assign match    = (stat.count == plen) && stat.prefix_ok;
   // held bytes that can no longer start a match, or all of them at end of text
   assign drain_go = (stat.count != '0) &&
                     (eot_ff || (stat.count >= plen) || !stat.prefix_ok);
   assign repl_go  = (ri_ff != rlen);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = match ? ST_REPL : ST_DRAIN;
         end
         ST_REPL: begin
            if (!repl_go) begin
               state_in = (eot_ff && (rlen == '0)) ? ST_EMPTY : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (!drain_go) begin
               state_in = (eot_ff && !emitted_ff) ? ST_EMPTY : ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ready         = 1'b0;
      ctrl          = '0;
      emit          = '0;
      eot_in        = eot_ff;
      emitted_in    = emitted_ff;
      ri_in         = ri_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ready     = 1'b1;
            ctrl.load = req_fire;
            if (req_fire) begin
               eot_in     = req_eot;
               emitted_in = 1'b0;
            end
         end
         ST_CHECK: begin
            ctrl.clear = match;
            ri_in      = '0;
         end
         ST_REPL: begin
            if (repl_go && slot_free) begin
               emit.valid    = 1'b1;
               emit.char_out = replace_bytes[8*ri_ff[REP_IDX_W-1:0] +: 8];
               emit.has_char = 1'b1;
               emit.last_out = eot_ff && (ri_ff == rlen - LEN_W'(1));
               ri_in         = ri_ff + LEN_W'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_go && slot_free) begin
               ctrl.shift    = 1'b1;
               emit.valid    = 1'b1;
               emit.char_out = stat.head;
               emit.has_char = 1'b1;
               emit.last_out = eot_ff && (stat.count == CNT_W'(1));
               emitted_in    = 1'b1;
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               emit.valid    = 1'b1;
               emit.last_out = 1'b1;
            end
         end
         default: begin
            ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         eot_ff     <= 1'b0;
         emitted_ff <= 1'b0;
         ri_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         eot_ff     <= eot_in;
         emitted_ff <= emitted_in;
         ri_ff      <= ri_in;
      end
   end
endmodule
`default_nettype wire

### sv/sfr_checker.sv
// Port-level checks for the stream find-and-replace block, bound to the top level.
`default_nettype none
module sfr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_char_out,
   input wire logic       rsp_has_char,
   input wire logic       rsp_last_out
);
   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_char_out) &&
         $stable(rsp_has_char) && $stable(rsp_last_out)))
      else $error("result beat changed while stalled");

   // an empty beat is only ever the end marker
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_char) |-> (rsp_last_out && (rsp_char_out == 8'd0)))
      else $error("empty result beat without end marker");

   // one byte in at a time: busy right after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while still working");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!req_stall && !rsp_valid))
      else $error("not idle after reset");
endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_char_out (rsp_char_out),
   .rsp_has_char (rsp_has_char),
   .rsp_last_out (rsp_last_out)
);
`default_nettype wire

### test/find_replace_checker.sv
// Checker for the stream find-and-replace unit: watches the channels, predicts and compares.
module find_replace_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [7:0]                     req_char_in,
   input  wire logic                           req_end_of_text,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [7:0]                     rsp_char_out,
   input  wire logic                           rsp_has_char,
   input  wire logic                           rsp_last_out,
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      byte_type char_out;
      logic     has_char;
      logic     last_out;
   } text_beat_type;

   // configuration copy, updated from the write port
   logic [LEN_W-1:0] pat_len_r;
   logic [63:0]      pat_lo_r;
   logic [63:0]      pat_hi_r;
   logic [LEN_W-1:0] rep_len_r;
   logic [63:0]      rep_lo_r;
   logic [63:0]      rep_hi_r;

   byte_type      held[MAX_PATTERN];
   int            held_cnt;
   text_beat_type expected_text[$];
   int            mismatches = 0;

   function automatic byte_type pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int i);
      logic [63:0] w;
      w = (i < 8) ? lo : hi;
      return w[8*(i%8) +: 8];
   endfunction

   function automatic bit held_is_prefix(input int n);
      for (int i = 0; i < n; i++)
         if (held[i] != pick_byte(pat_lo_r, pat_hi_r, i)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void expect_beat(input byte_type c, input logic has);
      text_beat_type b;
      b.char_out = c;
      b.has_char = has;
      b.last_out = 1'b0;
      expected_text.push_back(b);
   endfunction

   // one text byte in, the output bytes it releases appended to expected_text
   task automatic replace_step(input byte_type c, input logic eot);
      int            plen;
      int            rlen;
      int            made;
      text_beat_type b;
      plen = (pat_len_r == 0) ? 1 : ((pat_len_r > PAT_CAP) ? PAT_CAP : int'(pat_len_r));
      rlen = (rep_len_r > REPL_MAX) ? REPL_MAX : int'(rep_len_r);
      made = 0;
      if (held_cnt < MAX_PATTERN) begin
         held[held_cnt] = c;
         held_cnt++;
      end
      if (held_cnt == plen && held_is_prefix(plen)) begin
         for (int i = 0; i < rlen; i++) begin
            expect_beat(pick_byte(rep_lo_r, rep_hi_r, i), 1'b1);
            made++;
         end
         held_cnt = 0;
      end else begin
         // release oldest bytes until the rest can still start a match
         while (held_cnt > 0 && (held_cnt >= plen || !held_is_prefix(held_cnt))) begin
            expect_beat(held[0], 1'b1);
            made++;
            for (int i = 1; i < held_cnt; i++) held[i-1] = held[i];
            held_cnt--;
         end
      end
      if (eot) begin
         for (int i = 0; i < held_cnt; i++) begin
            expect_beat(held[i], 1'b1);
            made++;
         end
         held_cnt = 0;
         if (made == 0) expect_beat(8'h00, 1'b0);
         b = expected_text.pop_back();
         b.last_out = 1'b1;
         expected_text.push_back(b);
      end
   endtask

   always @(posedge clock) begin : watch
      text_beat_type want;
      if (reset) begin
         pat_len_r = 1;
         pat_lo_r  = '0;
         pat_hi_r  = '0;
         rep_len_r = '0;
         rep_lo_r  = '0;
         rep_hi_r  = '0;
         held_cnt  = 0;
         expected_text.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_LEN:  pat_len_r = csr_data[LEN_W-1:0];
               CSR_PATTERN_LOW:  pat_lo_r  = csr_data;
               CSR_PATTERN_HIGH: pat_hi_r  = csr_data;
               CSR_REPLACE_LEN:  rep_len_r = csr_data[LEN_W-1:0];
               CSR_REPLACE_LOW:  rep_lo_r  = csr_data;
               CSR_REPLACE_HIGH: rep_hi_r  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) replace_step(req_char_in, req_end_of_text);
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected beat char %h has %b last %b", $realtime,
                           rsp_char_out, rsp_has_char, rsp_last_out);
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_out !== want.char_out || rsp_has_char !== want.has_char ||
                   rsp_last_out !== want.last_out) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: beat mismatch: expected char %h has %b last %b, got %h %b %b",
                              $realtime, want.char_out, want.has_char, want.last_out,
                              rsp_char_out, rsp_has_char, rsp_last_out);
               end
            end
         end
      end
      pending    <= expected_text.size();
      fail_count <= mismatches;
   end
endmodule

### test/tb.sv
// Testbench top for the stream find-and-replace unit: stimulus, stalls and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 85;
   localparam int TIMEOUT_CYCLES = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic [7:0]            req_char_in = '0;
   logic                  req_end_of_text = 1'b0;
   logic                  rsp_stall = 1'b0;
   wire logic             req_stall;
   wire logic             rsp_valid;
   wire logic [7:0]       rsp_char_out;
   wire logic             rsp_has_char;
   wire logic             rsp_last_out;
   int                    errors;
   int                    pending;

   int tx_idle_pct = 27;
   int rx_idle_pct = 68;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;
   int beats_sent  = 0;

   // current pattern as the stimulus sees it, plus a few symbols to build texts from
   byte_type pat_bytes[16];
   int       pat_eff = 1;
   byte_type sym[4];

   stream_find_replace_unit dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_in(req_char_in), .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_char_out(rsp_char_out), .rsp_has_char(rsp_has_char), .rsp_last_out(rsp_last_out)
   );

   find_replace_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_in(req_char_in), .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_char_out(rsp_char_out), .rsp_has_char(rsp_has_char), .rsp_last_out(rsp_last_out),
      .fail_count(errors), .pending(pending)
   );

   always #HALF_PERIOD clock = ~clock;

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_stall   <= 1'b1;
         hold_left   <= LONG_HOLD - 1;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic send_beat(input byte_type c, input logic eot);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_in     <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_str(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], close && (i == s.len() - 1));
   endtask

   // stop sending until every predicted beat is out, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   task automatic load_setting(input logic [4:0] plen_raw, input logic [63:0] plo,
                               input logic [63:0] phi, input logic [4:0] rlen_raw,
                               input logic [63:0] rlo, input logic [63:0] rhi);
      csr_put(CSR_PATTERN_LEN, {59'd0, plen_raw});
      csr_put(CSR_PATTERN_LOW, plo);
      csr_put(CSR_PATTERN_HIGH, phi);
      csr_put(CSR_REPLACE_LEN, {59'd0, rlen_raw});
      csr_put(CSR_REPLACE_LOW, rlo);
      csr_put(CSR_REPLACE_HIGH, rhi);
      csr_write <= 1'b0;
      pat_eff = (plen_raw == 0) ? 1 : ((plen_raw > PAT_CAP) ? PAT_CAP : int'(plen_raw));
      for (int i = 0; i < 8; i++) begin
         pat_bytes[i]   = plo[8*i +: 8];
         pat_bytes[i+8] = phi[8*i +: 8];
      end
   endtask

   task automatic pick_setting();
      logic [4:0]  plen_raw;
      logic [4:0]  rlen_raw;
      logic [63:0] plo;
      logic [63:0] phi;
      int          r;
      int          pe;
      r = $urandom_range(99);
      if (r < 12)      plen_raw = 5'd16;
      else if (r < 17) plen_raw = 5'd0;
      else if (r < 22) plen_raw = 5'($urandom_range(31, 17));
      else if (r < 32) plen_raw = 5'($urandom_range(15, 6));
      else             plen_raw = 5'($urandom_range(5, 1));
      pe = (plen_raw == 0) ? 1 : ((plen_raw > PAT_CAP) ? PAT_CAP : int'(plen_raw));
      foreach (sym[k]) sym[k] = 8'($urandom_range(255));
      plo = {$urandom(), $urandom()};
      phi = {$urandom(), $urandom()};
      // a small alphabet keeps matches and near-misses frequent
      for (int i = 0; i < pe; i++) begin
         if (i < 8) plo[8*i +: 8] = sym[$urandom_range(3)];
         else       phi[8*(i-8) +: 8] = sym[$urandom_range(3)];
      end
      r = $urandom_range(99);
      if (r < 12)      rlen_raw = 5'd0;
      else if (r < 24) rlen_raw = 5'd16;
      else if (r < 30) rlen_raw = 5'($urandom_range(31, 17));
      else             rlen_raw = 5'($urandom_range(6, 1));
      load_setting(plen_raw, plo, phi, rlen_raw, {$urandom(), $urandom()},
                   {$urandom(), $urandom()});
   endtask

   function automatic byte_type text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 6)       return 8'($urandom_range(255));
      else if (r < 55) return pat_bytes[$urandom_range(pat_eff - 1)];
      else             return sym[$urandom_range(3)];
   endfunction

   // text made of whole matches, broken prefixes and filler
   task automatic send_random_text(input bit close);
      byte_type txt[$];
      int       r;
      int       n;
      repeat ($urandom_range(5, 1)) begin
         r = $urandom_range(99);
         if (r < 40) begin
            for (int i = 0; i < pat_eff; i++) txt.push_back(pat_bytes[i]);
         end else if (r < 65 && pat_eff > 1) begin
            n = $urandom_range(pat_eff - 1, 1);
            for (int i = 0; i < n; i++) txt.push_back(pat_bytes[i]);
            txt.push_back(text_byte());
         end else begin
            repeat ($urandom_range(4, 1)) txt.push_back(text_byte());
         end
      end
      foreach (txt[i]) send_beat(txt[i], close && (i == txt.size() - 1));
   endtask

   initial begin : stimulus
      int phase_end;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pattern "aab", replacement "XY"
      load_setting(5'd3, {$urandom(), 8'h00, 24'h626161}, {$urandom(), $urandom()},
                   5'd2, {$urandom(), 16'h0000, 16'h5958}, {$urandom(), $urandom()});
      send_str("aaab", 1'b0);       // partial match slides by one, then matches
      send_str("x", 1'b1);
      send_str("a", 1'b1);          // held prefix flushed at end of text
      send_str("aab", 1'b1);        // match closes the text
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b1);
      send_str("aa", 1'b0);         // left held across the pattern change
      wait_idle();
      // zero length acts as one, pattern "a", matches deleted
      load_setting(5'd0, {$urandom(), 24'h0, 8'h61}, {$urandom(), $urandom()},
                   5'd0, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      send_str("b", 1'b1);          // stale held bytes go out unchanged
      send_str("a", 1'b1);          // deleted, so the end marker is empty
      wait_idle();
      // oversized lengths clamp to sixteen
      load_setting(5'd31, '1, '1, 5'd31, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      repeat (3) send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b1);

      for (int ph = 0; ph < 3; ph++) begin
         wait_idle();
         case (ph)
            0: begin
               tx_idle_pct = 27;
               rx_idle_pct <= 68;
            end
            1: begin
               tx_idle_pct = 68;
               rx_idle_pct <= 27;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
            end
         endcase
         phase_end = beats_sent + PHASE_ITEMS;
         if (ph == 2) begin
            wait_idle();
            pick_setting();
            // receiver holds off while beats keep coming, so the input backs up
            hold_asked <= hold_asked + 1;
            repeat (40) send_beat(text_byte(), 1'b0);
            send_beat(text_byte(), 1'b1);
         end
         while (beats_sent < phase_end) begin
            wait_idle();
            pick_setting();
            repeat ($urandom_range(4, 2)) send_random_text($urandom_range(9) != 0);
         end
      end

      wait_idle();
      if (errors == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("Some tests failed");
      $finish;
   end
endmodule

### filelist.f
sv/sfr_pkg.sv
sv/sfr_held.sv
sv/sfr_seq.sv
sv/stream_find_replace_unit.sv
sv/sfr_checker.sv
test/find_replace_checker.sv
test/tb.sv
